### hdl/acs_pkg.sv
// Package: shared constants, opcodes and controller/datapath interface types.
`timescale 1ns / 1ps
package acs_pkg;
   localparam int MEM_DEPTH_DEFAULT = 65536;
   localparam logic [15:0] PC_RESET = 16'h0100;
   localparam logic [15:0] SP_RESET = 16'hFFFE;
   localparam logic [7:0]  NO_CHAR  = 8'hFF;

   localparam logic [7:0] OP_LDA_I = 8'd0;
   localparam logic [7:0] OP_LDA_M = 8'd1;
   localparam logic [7:0] OP_STA   = 8'd2;
   localparam logic [7:0] OP_ADD_I = 8'd3;
   localparam logic [7:0] OP_ADD_M = 8'd4;
   localparam logic [7:0] OP_INC   = 8'd5;
   localparam logic [7:0] OP_DEC   = 8'd6;
   localparam logic [7:0] OP_BRNZ  = 8'd7;
   localparam logic [7:0] OP_OUT   = 8'd8;
   localparam logic [7:0] OP_JMP   = 8'd9;
   localparam logic [7:0] OP_JSR   = 8'd10;
   localparam logic [7:0] OP_RET   = 8'd11;
   localparam logic [7:0] OP_LDI_I = 8'd12;
   localparam logic [7:0] OP_LDI_M = 8'd13;
   localparam logic [7:0] OP_INCI  = 8'd14;
   localparam logic [7:0] OP_DECI  = 8'd15;
   localparam logic [7:0] OP_LDAI  = 8'd16;
   localparam logic [7:0] OP_LDAIO = 8'd17;
   localparam logic [7:0] OP_STAI  = 8'd18;
   localparam logic [7:0] OP_STAIO = 8'd19;
   localparam logic [7:0] OP_HALT  = 8'd20;

   // memory address source
   localparam logic [2:0] AS_PC   = 3'd0;
   localparam logic [2:0] AS_OPW  = 3'd1; // operand word
   localparam logic [2:0] AS_OPW1 = 3'd2; // operand word + 1
   localparam logic [2:0] AS_SP   = 3'd3;
   localparam logic [2:0] AS_IX   = 3'd4;
   localparam logic [2:0] AS_IXO  = 3'd5; // index + offset byte
   localparam logic [2:0] AS_REQ  = 3'd6;

   // write data source
   localparam logic [1:0] WS_ACC  = 2'd0;
   localparam logic [1:0] WS_PCH  = 2'd1;
   localparam logic [1:0] WS_PCL  = 2'd2;
   localparam logic [1:0] WS_REQ  = 2'd3;

   // register action applied at the end of a cycle
   localparam logic [3:0] RA_NONE   = 4'd0;
   localparam logic [3:0] RA_OPHI   = 4'd1; // read byte to opword high, low kept
   localparam logic [3:0] RA_OPLO   = 4'd2; // capture read byte as opword low
   localparam logic [3:0] RA_ACC_LD = 4'd3;
   localparam logic [3:0] RA_ACC_AD = 4'd4;
   localparam logic [3:0] RA_ACC_IN = 4'd5;
   localparam logic [3:0] RA_ACC_DE = 4'd6;
   localparam logic [3:0] RA_PC_OPW = 4'd7;
   localparam logic [3:0] RA_IX_OPW = 4'd8;
   localparam logic [3:0] RA_IX_INC = 4'd9;
   localparam logic [3:0] RA_IX_DEC = 4'd10;
   localparam logic [3:0] RA_ZERO   = 4'd11; // set zero flag from acc
   localparam logic [3:0] RA_IX_HI  = 4'd12; // index high byte from read
   localparam logic [3:0] RA_IX_LO  = 4'd13;
   localparam logic [3:0] RA_HALT   = 4'd14;
   localparam logic [3:0] RA_EMIT   = 4'd15;

   typedef struct packed {
      logic       mem_rd;
      logic       mem_wr;
      logic [2:0] addr_sel;
      logic [1:0] wdata_sel;
      logic       pc_inc;
      logic       sp_inc;
      logic       sp_dec;
      logic [3:0] reg_act;
      logic       clr_emit;
      logic       cond_brnz;
   } cmd_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic       halted;
      logic       clearing;   // memory clear pass after reset still running
   } stat_type;
endpackage

### hdl/acs_datapath.sv
// Datapath: single-port byte memory, machine registers and operand latch.
`timescale 1ns / 1ps
module acs_datapath #(
   parameter int MEM_DEPTH = acs_pkg::MEM_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  acs_pkg::cmd_type   cmd,
   input  logic [15:0]        req_address,
   input  logic [7:0]         req_data,
   output acs_pkg::stat_type  stat,
   output logic [15:0]        pc,
   output logic [7:0]         acc,
   output logic [15:0]        ix,
   output logic [15:0]        sp,
   output logic               zf,
   output logic               emit_v,
   output logic [7:0]         emit_c
);
   localparam int AW = $clog2(MEM_DEPTH);

   logic [7:0]  mem [MEM_DEPTH];
   logic [7:0]  rdata_ff;
   logic [15:0] pc_ff, ix_ff, sp_ff, opw_ff;
   logic [7:0]  acc_ff, ch_ff;
   logic        zf_ff, halt_ff, ev_ff;
   logic        clr_busy_ff;
   logic [AW-1:0] clr_addr_ff;
   logic [15:0] addr_in;
   logic [7:0]  wdata_in;

   always_comb begin
      case (cmd.addr_sel)
         acs_pkg::AS_PC:   addr_in = pc_ff;
         acs_pkg::AS_OPW:  addr_in = opw_ff;
         acs_pkg::AS_OPW1: addr_in = opw_ff + 16'd1;
         acs_pkg::AS_SP:   addr_in = sp_ff;
         acs_pkg::AS_IX:   addr_in = ix_ff;
         acs_pkg::AS_IXO:  addr_in = ix_ff + {8'd0, opw_ff[7:0]};
         default:          addr_in = req_address;
      endcase
      case (cmd.wdata_sel)
         acs_pkg::WS_ACC: wdata_in = acc_ff;
         acs_pkg::WS_PCH: wdata_in = pc_ff[15:8];
         acs_pkg::WS_PCL: wdata_in = pc_ff[7:0];
         default:         wdata_in = req_data;
      endcase
   end

   // after reset one byte per cycle is cleared, from address 0 to MEM_DEPTH-1
   always_ff @(posedge clock) begin
      if (clr_busy_ff) mem[clr_addr_ff] <= 8'd0;
      else if (cmd.mem_wr) mem[addr_in[AW-1:0]] <= wdata_in;
      if (cmd.mem_rd) rdata_ff <= mem[addr_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + {{(AW-1){1'b0}}, 1'b1};
         if (clr_addr_ff == AW'(MEM_DEPTH - 1)) clr_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= acs_pkg::PC_RESET;
         sp_ff <= acs_pkg::SP_RESET;
         ix_ff <= '0; acc_ff <= '0; zf_ff <= 1'b0; halt_ff <= 1'b0;
         ev_ff <= 1'b0; ch_ff <= '0; opw_ff <= '0;
      end else begin
         if (cmd.clr_emit) begin
            ev_ff <= 1'b0; ch_ff <= '0;
         end
         if (cmd.pc_inc) pc_ff <= pc_ff + 16'd1;
         if (cmd.sp_inc) sp_ff <= sp_ff + 16'd1;
         if (cmd.sp_dec) sp_ff <= sp_ff - 16'd1;
         case (cmd.reg_act)
            acs_pkg::RA_OPHI:   opw_ff <= {rdata_ff, opw_ff[7:0]};
            acs_pkg::RA_OPLO:   opw_ff <= {opw_ff[15:8], rdata_ff};
            acs_pkg::RA_ACC_LD: acc_ff <= rdata_ff;
            acs_pkg::RA_ACC_AD: acc_ff <= acc_ff + rdata_ff;
            acs_pkg::RA_ACC_IN: acc_ff <= acc_ff + 8'd1;
            acs_pkg::RA_ACC_DE: acc_ff <= acc_ff - 8'd1;
            acs_pkg::RA_PC_OPW: begin
               if (!cmd.cond_brnz || !zf_ff) pc_ff <= opw_ff;
            end
            acs_pkg::RA_IX_OPW: ix_ff <= opw_ff;
            acs_pkg::RA_IX_INC: ix_ff <= ix_ff + 16'd1;
            acs_pkg::RA_IX_DEC: ix_ff <= ix_ff - 16'd1;
            acs_pkg::RA_ZERO:   zf_ff <= (acc_ff == 8'd0);
            acs_pkg::RA_IX_HI:  ix_ff <= {rdata_ff, ix_ff[7:0]};
            acs_pkg::RA_IX_LO:  ix_ff <= {ix_ff[15:8], rdata_ff};
            acs_pkg::RA_HALT:   halt_ff <= 1'b1;
            acs_pkg::RA_EMIT: begin
               if (acc_ff != acs_pkg::NO_CHAR) begin
                  ev_ff <= 1'b1; ch_ff <= acc_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign stat.rdata    = rdata_ff;
   assign stat.halted   = halt_ff;
   assign stat.clearing = clr_busy_ff;
   assign pc = pc_ff; assign acc = acc_ff; assign ix = ix_ff; assign sp = sp_ff;
   assign zf = zf_ff; assign emit_v = ev_ff; assign emit_c = ch_ff;

   a_no_rw: assert property (@(posedge clock) disable iff (reset)
      !(cmd.mem_rd && cmd.mem_wr)) else $error("read and write in one cycle");
   a_sp_one: assert property (@(posedge clock) disable iff (reset)
      !(cmd.sp_inc && cmd.sp_dec)) else $error("sp inc and dec together");
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff) else $error("halt cleared");
endmodule

### hdl/acs_control.sv
// Controller: sequencer that steps one instruction through fetch and execute.
`timescale 1ns / 1ps
module acs_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_op,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  acs_pkg::stat_type stat,
   output acs_pkg::cmd_type  cmd
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_OPC  = 4'd1;  // opcode byte in rdata
   localparam logic [3:0] S_B1   = 4'd2;  // first operand byte in rdata
   localparam logic [3:0] S_B2   = 4'd3;  // second operand byte in rdata
   localparam logic [3:0] S_EX   = 4'd4;  // operand word ready
   localparam logic [3:0] S_EX2  = 4'd5;
   localparam logic [3:0] S_EX3  = 4'd6;
   localparam logic [3:0] S_EX4  = 4'd7;
   localparam logic [3:0] S_FLAG = 4'd8;
   localparam logic [3:0] S_RSP  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [7:0] op_ff, op_in;
   logic       rsp_busy;

   assign rsp_busy   = (state_ff == S_RSP) && !rsp_tready;
   // held off while the memory clear pass runs
   assign req_tready = !stat.clearing &&
                       ((state_ff == S_IDLE) || ((state_ff == S_RSP) && rsp_tready));
   assign rsp_tvalid = (state_ff == S_RSP);

   function automatic logic one_byte(input logic [7:0] o);
      return o == acs_pkg::OP_LDA_I || o == acs_pkg::OP_ADD_I ||
             o == acs_pkg::OP_LDAIO || o == acs_pkg::OP_STAIO;
   endfunction
   function automatic logic two_byte(input logic [7:0] o);
      return o == acs_pkg::OP_LDA_M || o == acs_pkg::OP_STA ||
             o == acs_pkg::OP_ADD_M || o == acs_pkg::OP_BRNZ ||
             o == acs_pkg::OP_JMP || o == acs_pkg::OP_JSR ||
             o == acs_pkg::OP_LDI_I || o == acs_pkg::OP_LDI_M;
   endfunction

   always_comb begin
      cmd = '0;
      cmd.addr_sel = acs_pkg::AS_PC;
      cmd.reg_act = acs_pkg::RA_NONE;
      state_in = state_ff;
      op_in = op_ff;
      if (req_tready && req_tvalid) begin
         cmd.clr_emit = 1'b1;
         if (!req_op) begin
            cmd.mem_wr = 1'b1;
            cmd.addr_sel = acs_pkg::AS_REQ;
            cmd.wdata_sel = acs_pkg::WS_REQ;
            state_in = S_RSP;
         end else if (stat.halted) begin
            state_in = S_RSP;
         end else begin
            cmd.mem_rd = 1'b1; cmd.pc_inc = 1'b1;
            state_in = S_OPC;
         end
      end else if (rsp_busy) begin
         state_in = S_RSP;
      end else begin
         case (state_ff)
            S_OPC: begin
               op_in = stat.rdata;
               if (one_byte(stat.rdata) || two_byte(stat.rdata)) begin
                  cmd.mem_rd = 1'b1; cmd.pc_inc = 1'b1; state_in = S_B1;
               end else begin
                  state_in = S_EX;
               end
            end
            S_B1: begin
               if (two_byte(op_ff)) begin
                  cmd.reg_act = acs_pkg::RA_OPHI;
                  cmd.mem_rd = 1'b1; cmd.pc_inc = 1'b1; state_in = S_B2;
               end else begin
                  cmd.reg_act = acs_pkg::RA_OPLO; state_in = S_EX;
               end
            end
            S_B2: begin
               cmd.reg_act = acs_pkg::RA_OPLO; state_in = S_EX;
            end
            S_EX: begin
               state_in = S_RSP;
               case (op_ff)
                  acs_pkg::OP_LDA_I, acs_pkg::OP_ADD_I: begin
                     cmd.reg_act = (op_ff == acs_pkg::OP_LDA_I) ?
                        acs_pkg::RA_ACC_LD : acs_pkg::RA_ACC_AD;
                     state_in = S_FLAG;
                  end
                  acs_pkg::OP_LDA_M, acs_pkg::OP_ADD_M: begin
                     cmd.mem_rd = 1'b1; cmd.addr_sel = acs_pkg::AS_OPW;
                     state_in = S_EX2;
                  end
                  acs_pkg::OP_LDAI: begin
                     cmd.mem_rd = 1'b1; cmd.addr_sel = acs_pkg::AS_IX;
                     state_in = S_EX2;
                  end
                  acs_pkg::OP_LDAIO: begin
                     cmd.mem_rd = 1'b1; cmd.addr_sel = acs_pkg::AS_IXO;
                     state_in = S_EX2;
                  end
                  acs_pkg::OP_STA: begin
                     cmd.mem_wr = 1'b1; cmd.addr_sel = acs_pkg::AS_OPW;
                     cmd.reg_act = acs_pkg::RA_ZERO;
                  end
                  acs_pkg::OP_STAI: begin
                     cmd.mem_wr = 1'b1; cmd.addr_sel = acs_pkg::AS_IX;
                     cmd.reg_act = acs_pkg::RA_ZERO;
                  end
                  acs_pkg::OP_STAIO: begin
                     cmd.mem_wr = 1'b1; cmd.addr_sel = acs_pkg::AS_IXO;
                     cmd.reg_act = acs_pkg::RA_ZERO;
                  end
                  acs_pkg::OP_INC: begin
                     cmd.reg_act = acs_pkg::RA_ACC_IN; state_in = S_FLAG;
                  end
                  acs_pkg::OP_DEC: begin
                     cmd.reg_act = acs_pkg::RA_ACC_DE; state_in = S_FLAG;
                  end
                  acs_pkg::OP_BRNZ: begin
                     cmd.reg_act = acs_pkg::RA_PC_OPW; cmd.cond_brnz = 1'b1;
                  end
                  acs_pkg::OP_JMP: cmd.reg_act = acs_pkg::RA_PC_OPW;
                  acs_pkg::OP_OUT: cmd.reg_act = acs_pkg::RA_EMIT;
                  acs_pkg::OP_JSR: begin
                     cmd.mem_wr = 1'b1; cmd.addr_sel = acs_pkg::AS_SP;
                     cmd.wdata_sel = acs_pkg::WS_PCH; cmd.sp_dec = 1'b1;
                     state_in = S_EX2;
                  end
                  acs_pkg::OP_RET: begin
                     cmd.sp_inc = 1'b1; state_in = S_EX2;
                  end
                  acs_pkg::OP_LDI_I: cmd.reg_act = acs_pkg::RA_IX_OPW;
                  acs_pkg::OP_LDI_M: begin
                     cmd.mem_rd = 1'b1; cmd.addr_sel = acs_pkg::AS_OPW;
                     state_in = S_EX2;
                  end
                  acs_pkg::OP_INCI: cmd.reg_act = acs_pkg::RA_IX_INC;
                  acs_pkg::OP_DECI: cmd.reg_act = acs_pkg::RA_IX_DEC;
                  acs_pkg::OP_HALT: cmd.reg_act = acs_pkg::RA_HALT;
                  default: ;
               endcase
            end
            S_EX2: begin
               state_in = S_RSP;
               case (op_ff)
                  acs_pkg::OP_ADD_M: begin
                     cmd.reg_act = acs_pkg::RA_ACC_AD; state_in = S_FLAG;
                  end
                  acs_pkg::OP_JSR: begin
                     cmd.mem_wr = 1'b1; cmd.addr_sel = acs_pkg::AS_SP;
                     cmd.wdata_sel = acs_pkg::WS_PCL; cmd.sp_dec = 1'b1;
                     state_in = S_EX3;
                  end
                  acs_pkg::OP_RET: begin
                     cmd.mem_rd = 1'b1; cmd.addr_sel = acs_pkg::AS_SP;
                     cmd.sp_inc = 1'b1; state_in = S_EX3;
                  end
                  acs_pkg::OP_LDI_M: begin
                     cmd.reg_act = acs_pkg::RA_IX_HI;
                     cmd.mem_rd = 1'b1; cmd.addr_sel = acs_pkg::AS_OPW1;
                     state_in = S_EX3;
                  end
                  default: begin
                     cmd.reg_act = acs_pkg::RA_ACC_LD; state_in = S_FLAG;
                  end
               endcase
            end
            S_EX3: begin
               state_in = S_RSP;
               case (op_ff)
                  acs_pkg::OP_JSR: cmd.reg_act = acs_pkg::RA_PC_OPW;
                  acs_pkg::OP_RET: begin
                     cmd.reg_act = acs_pkg::RA_OPLO;
                     cmd.mem_rd = 1'b1; cmd.addr_sel = acs_pkg::AS_SP;
                     state_in = S_EX4;
                  end
                  default: cmd.reg_act = acs_pkg::RA_IX_LO;
               endcase
            end
            S_EX4: begin
               cmd.reg_act = acs_pkg::RA_OPHI; state_in = S_FLAG;
            end
            S_FLAG: begin
               state_in = S_RSP;
               if (op_ff == acs_pkg::OP_RET) cmd.reg_act = acs_pkg::RA_PC_OPW;
               else cmd.reg_act = acs_pkg::RA_ZERO;
            end
            S_RSP: state_in = S_IDLE;
            default: state_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; op_ff <= '0;
      end else begin
         state_ff <= state_in; op_ff <= op_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("response dropped");
   a_busy_nrdy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_RSP) |-> !req_tready)
      else $error("accept while busy");
   a_onemem: assert property (@(posedge clock) disable iff (reset)
      !(cmd.mem_rd && cmd.mem_wr)) else $error("two memory ops");
endmodule

### hdl/accumulator_cpu_step.sv
// Top level: accumulator machine that takes byte loads and single steps.
`timescale 1ns / 1ps
// Each request transfer is a byte load (opcode 0) or one instruction step
// (opcode 1) and yields exactly one response transfer carrying the register
// state after it. A load, or a step after HALT, goes straight to the response;
// a step fetches its opcode and operand bytes and then makes its data or stack
// accesses in turn, as the single port memory serves one fetch, data or stack
// access per cycle. The next request is taken in the cycle the response
// transfers. After reset a clear pass zeroes the memory one byte per cycle, and
// req_tready stays low until it is done. After HALT steps report state only.
module accumulator_cpu_step #(
   parameter int MEM_DEPTH = acs_pkg::MEM_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // opcode
   input  logic [23:0] req_tdata,   // address[15:0], data[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // prog_counter[15:0] accumulator[23:16] index_reg[39:24] stack_ptr[55:40]
   // zflag[56] char_valid[57] char_value[65:58] halted[66], zero pad
   output logic [71:0] rsp_tdata
);
   acs_pkg::cmd_type  cmd;
   acs_pkg::stat_type stat;
   logic [15:0] pc, ix, sp;
   logic [7:0]  acc, ch;
   logic        zf, ev;

   acs_control u_ctl (
      .clock, .reset, .req_tvalid, .req_tready, .req_op(req_tuser),
      .rsp_tvalid, .rsp_tready, .stat, .cmd
   );

   acs_datapath #(.MEM_DEPTH(MEM_DEPTH)) u_dp (
      .clock, .reset, .cmd,
      .req_address(req_tdata[15:0]), .req_data(req_tdata[23:16]),
      .stat, .pc, .acc, .ix, .sp, .zf, .emit_v(ev), .emit_c(ch)
   );

   assign rsp_tdata = {5'd0, stat.halted, ch, ev, zf, sp, ix, acc, pc};
endmodule

### tb/sv/tb_accumulator_cpu_step.sv
// Testbench for accumulator_cpu_step: byte loads and instruction steps checked against a predictor.
`timescale 1ns / 1ps
module tb_accumulator_cpu_step;
   localparam int NUM_ITEMS   = 1900;
   localparam int QUIET_AFTER = 1700;  // no idling on either side past this item
   // cycles without any transfer; covers the memory clear pass after reset
   localparam int STALL_LIMIT = 4 * acs_pkg::MEM_DEPTH_DEFAULT;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser = 1'b0;   // opcode
   logic [23:0] req_tdata = '0;     // address[15:0], data[23:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   // prog_counter[15:0] accumulator[23:16] index_reg[39:24] stack_ptr[55:40]
   // zflag[56] char_valid[57] char_value[65:58] halted[66], zero pad
   logic [71:0] rsp_tdata;

   accumulator_cpu_step dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // machine image kept by the predictor; memory starts cleared
   logic [7:0]  mem_img [0:65535];
   bit          mem_set [0:65535];   // byte has been loaded or stored
   logic [15:0] st_pc   = acs_pkg::PC_RESET;
   logic [15:0] st_sp   = acs_pkg::SP_RESET;
   logic [15:0] st_ix   = '0;
   logic [7:0]  st_acc  = '0;
   logic        st_z    = 1'b0;
   logic        st_halt = 1'b0;

   logic [71:0] expected_state [$];
   int          items_sent = 0;
   int          errors = 0;
   int          idle_cycles = 0;
   bit          quiet = 1'b0;

   function automatic logic [71:0] pack_state(logic cv, logic [7:0] ch);
      return {5'b0, st_halt, ch, cv, st_z, st_sp, st_ix, st_acc, st_pc};
   endfunction

   // read one byte, noting the first address that was never loaded or stored
   function automatic logic [7:0] peek(logic [15:0] a, inout int miss);
      if (!mem_set[a] && miss < 0) miss = a;
      return mem_img[a];
   endfunction

   // Executes one instruction. With commit clear, only probes: returns the first
   // unloaded address the instruction would read, or -1. With commit set, updates
   // the image and returns the resulting response word in rsp.
   function automatic int cpu_exec(bit commit, output logic [71:0] rsp);
      logic [15:0] pc, sp, ix, a, a1;
      logic [7:0]  acc, op, b, hi, lo;
      logic        z, h, cv, setz;
      logic [7:0]  ch;
      logic [15:0] wa [2];
      logic [7:0]  wd [2];
      int          nw, miss;
      pc = st_pc; sp = st_sp; ix = st_ix; acc = st_acc; z = st_z; h = st_halt;
      cv = 1'b0; ch = '0; nw = 0; miss = -1; setz = 1'b0;
      rsp = pack_state(1'b0, 8'h00);
      if (h) return -1;
      op = peek(pc, miss); pc++;
      case (op)
         acs_pkg::OP_LDA_I, acs_pkg::OP_ADD_I, acs_pkg::OP_LDAIO,
         acs_pkg::OP_STAIO: begin
            b = peek(pc, miss); pc++;
         end
         acs_pkg::OP_LDA_M, acs_pkg::OP_STA, acs_pkg::OP_ADD_M, acs_pkg::OP_BRNZ,
         acs_pkg::OP_JMP, acs_pkg::OP_JSR, acs_pkg::OP_LDI_I,
         acs_pkg::OP_LDI_M: begin
            hi = peek(pc, miss); pc++;
            lo = peek(pc, miss); pc++;
            a = {hi, lo};
         end
         default: ;
      endcase
      case (op)
         acs_pkg::OP_LDA_I: begin acc = b; setz = 1'b1; end
         acs_pkg::OP_LDA_M: begin acc = peek(a, miss); setz = 1'b1; end
         acs_pkg::OP_STA: begin wa[0] = a; wd[0] = acc; nw = 1; setz = 1'b1; end
         acs_pkg::OP_ADD_I: begin acc = acc + b; setz = 1'b1; end
         acs_pkg::OP_ADD_M: begin acc = acc + peek(a, miss); setz = 1'b1; end
         acs_pkg::OP_INC: begin acc = acc + 8'd1; setz = 1'b1; end
         acs_pkg::OP_DEC: begin acc = acc - 8'd1; setz = 1'b1; end
         acs_pkg::OP_BRNZ: if (!z) pc = a;
         acs_pkg::OP_OUT: if (acc != acs_pkg::NO_CHAR) begin cv = 1'b1; ch = acc; end
         acs_pkg::OP_JMP: pc = a;
         acs_pkg::OP_JSR: begin
            // return address high byte goes in first, at the higher address
            wa[0] = sp; wd[0] = pc[15:8]; sp--;
            wa[1] = sp; wd[1] = pc[7:0];  sp--;
            nw = 2; pc = a;
         end
         acs_pkg::OP_RET: begin
            sp++; lo = peek(sp, miss);
            sp++; hi = peek(sp, miss);
            pc = {hi, lo};
         end
         acs_pkg::OP_LDI_I: ix = a;
         acs_pkg::OP_LDI_M: begin
            a1 = a + 16'd1;
            hi = peek(a, miss);
            lo = peek(a1, miss);
            ix = {hi, lo};
         end
         acs_pkg::OP_INCI: ix = ix + 16'd1;
         acs_pkg::OP_DECI: ix = ix - 16'd1;
         acs_pkg::OP_LDAI: begin acc = peek(ix, miss); setz = 1'b1; end
         acs_pkg::OP_LDAIO: begin
            a = ix + {8'h00, b}; acc = peek(a, miss); setz = 1'b1;
         end
         acs_pkg::OP_STAI: begin wa[0] = ix; wd[0] = acc; nw = 1; setz = 1'b1; end
         acs_pkg::OP_STAIO: begin
            a = ix + {8'h00, b};
            wa[0] = a; wd[0] = acc; nw = 1; setz = 1'b1;
         end
         acs_pkg::OP_HALT: h = 1'b1;
         default: ;  // unknown codes only move past the opcode byte
      endcase
      if (setz) z = (acc == 8'h00);
      if (miss >= 0 && !commit) return miss;
      if (commit) begin
         for (int i = 0; i < nw; i++) begin
            mem_img[wa[i]] = wd[i];
            mem_set[wa[i]] = 1'b1;
         end
         st_pc = pc; st_sp = sp; st_ix = ix; st_acc = acc; st_z = z; st_halt = h;
         rsp = pack_state(cv, ch);
      end
      return -1;
   endfunction

   function automatic logic [71:0] mem_load(logic [15:0] a, logic [7:0] d);
      mem_img[a] = d;
      mem_set[a] = 1'b1;
      return pack_state(1'b0, 8'h00);
   endfunction

   // any defined instruction but HALT, now and then an unknown code
   function automatic logic [7:0] pick_op();
      if ($urandom_range(0, 9) == 0)
         return 8'($urandom_range(acs_pkg::OP_HALT + 1, 255));
      return 8'($urandom_range(acs_pkg::OP_LDA_I, acs_pkg::OP_HALT - 1));
   endfunction

   // one request transfer, with a random gap before it while idling is on
   task automatic send(logic op, logic [15:0] a, logic [7:0] d, logic [71:0] exp_state);
      expected_state.push_back(exp_state);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {d, a};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      quiet = items_sent > QUIET_AFTER;
   endtask

   task automatic load_byte(logic [15:0] a, logic [7:0] d);
      send(1'b0, a, d, mem_load(a, d));
   endtask

   // Mostly loads the bytes the next instruction would read before stepping
   // it; now and then one is left alone so a cleared byte gets read. A stray
   // HALT at the PC is replaced unless the run is meant to stop.
   task automatic step_cpu(bit allow_halt);
      logic [71:0] rsp;
      int          miss;
      if (!st_halt && !allow_halt && mem_set[st_pc] && mem_img[st_pc] == acs_pkg::OP_HALT)
         load_byte(st_pc, pick_op());
      miss = cpu_exec(1'b0, rsp);
      while (miss >= 0 && $urandom_range(0, 3) != 0) begin
         load_byte(16'(miss), (miss == st_pc) ? pick_op() : 8'($urandom));
         miss = cpu_exec(1'b0, rsp);
      end
      miss = cpu_exec(1'b1, rsp);
      send(1'b1, 16'($urandom), 8'($urandom), rsp);
   endtask

   typedef struct {
      logic        op;
      logic [15:0] addr;
      logic [7:0]  data;
      bit          typed;
      logic [71:0] exp_state;
   } row_type;

   // Directed program at the reset PC: load 0xFF and OUT it (nothing emitted),
   // INC wraps to zero and OUT emits 0, DEC, JSR to the top of memory and RET.
   row_type table_rows [] = '{
      '{1'b0, 16'h0100, 8'h00, 1'b1, {5'b0, 1'b0, 8'h00, 1'b0, 1'b0,
                                      16'hFFFE, 16'h0000, 8'h00, 16'h0100}},
      '{1'b0, 16'h0101, 8'hFF, 1'b0, '0},
      '{1'b0, 16'h0102, acs_pkg::OP_OUT, 1'b0, '0},
      '{1'b0, 16'h0103, acs_pkg::OP_INC, 1'b0, '0},
      '{1'b0, 16'h0104, acs_pkg::OP_OUT, 1'b0, '0},
      '{1'b0, 16'h0105, acs_pkg::OP_DEC, 1'b0, '0},
      '{1'b0, 16'h0106, acs_pkg::OP_JSR, 1'b0, '0},
      '{1'b0, 16'h0107, 8'hFF, 1'b0, '0},
      '{1'b0, 16'h0108, 8'hFF, 1'b0, '0},
      '{1'b0, 16'hFFFF, acs_pkg::OP_RET, 1'b0, '0},
      '{1'b0, 16'h0000, 8'h00, 1'b0, '0},
      '{1'b1, 16'hFFFF, 8'hFF, 1'b0, '0},   // LDA_I 0xFF
      '{1'b1, 16'h0000, 8'h00, 1'b0, '0},   // OUT, no character
      '{1'b1, 16'hFFFF, 8'hFF, 1'b0, '0},   // INC to zero
      '{1'b1, 16'h0000, 8'h00, 1'b0, '0},   // OUT 0
      '{1'b1, 16'hFFFF, 8'hFF, 1'b0, '0},   // DEC
      '{1'b1, 16'h0000, 8'h00, 1'b0, '0},   // JSR 0xFFFF
      '{1'b1, 16'hFFFF, 8'hFF, 1'b0, '0},   // RET
      '{1'b1, 16'h0000, 8'h00, 1'b0, '0}
   };

   task automatic report(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   // response checker
   always @(posedge clock) begin
      logic [71:0] e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_state.size() == 0) begin
            $display("%0t unexpected response %h", $time, rsp_tdata);
            errors++;
         end else begin
            e = expected_state.pop_front();
            report("prog_counter", e[15:0], rsp_tdata[15:0]);
            report("accumulator", e[23:16], rsp_tdata[23:16]);
            report("index_reg", e[39:24], rsp_tdata[39:24]);
            report("stack_ptr", e[55:40], rsp_tdata[55:40]);
            report("zflag", e[56], rsp_tdata[56]);
            report("char_valid", e[57], rsp_tdata[57]);
            report("char_value", e[65:58], rsp_tdata[65:58]);
            report("halted", e[66], rsp_tdata[66]);
         end
      end
   end

   // response-side backpressure in random bursts
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 12);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      foreach (mem_img[i]) mem_img[i] = 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i]) begin
         if (table_rows[i].op) begin
            step_cpu(1'b0);
         end else if (table_rows[i].typed) begin
            void'(mem_load(table_rows[i].addr, table_rows[i].data));
            send(1'b0, table_rows[i].addr, table_rows[i].data, table_rows[i].exp_state);
         end else begin
            load_byte(table_rows[i].addr, table_rows[i].data);
         end
      end

      // mostly steps through self-built code; some loads near the PC or anywhere
      while (items_sent < NUM_ITEMS) begin
         case ($urandom_range(0, 19))
            0:       load_byte(16'($urandom), 8'($urandom));
            1:       load_byte(st_pc + 16'($urandom_range(0, 3)), pick_op());
            2:       load_byte(st_pc + 16'($urandom_range(0, 3)), 8'($urandom));
            default: step_cpu(1'b0);
         endcase
      end

      // HALT, then steps change nothing while loads still land
      load_byte(st_pc, acs_pkg::OP_HALT);
      step_cpu(1'b1);
      step_cpu(1'b1);
      load_byte(16'($urandom), 8'($urandom));
      step_cpu(1'b1);
      req_tvalid <= 1'b0;

      while (expected_state.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

### files.f
hdl/acs_pkg.sv
hdl/acs_datapath.sv
hdl/acs_control.sv
hdl/accumulator_cpu_step.sv
tb/sv/tb_accumulator_cpu_step.sv
